/* rtl/gdnms_pkg.sv */
// Shared types, widths, codes and the disk half-width function of the grid disk suppressor.
`timescale 1ns / 1ps
package gdnms_pkg;

  localparam int ID_W       = 16;
  localparam int LOC_W      = 19;
  localparam int LVL_W      = 2;
  localparam int STAT_W     = 2;
  localparam int INV_W      = 20;
  localparam int OFF_W      = 24;
  localparam int RAD_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Product of a location and the unsigned inverse radius, and the Q.20 sum.
  localparam int PROD_W = LOC_W + INV_W + 1;
  localparam int RAW_W  = PROD_W + 1;
  localparam int FRAC_W = 20;
  localparam int BIN_W  = RAW_W - FRAC_W;
  localparam int CW     = BIN_W + 1;
  // The disk row counter runs from 0 to 2r+1.
  localparam int CNT_W  = RAD_W + 1;

  localparam logic [STAT_W-1:0] ST_ACCEPT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SUPPRESS = 2'd1;
  localparam logic [STAT_W-1:0] ST_OUTSIDE  = 2'd2;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_RADIUS = 2'd3;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              mul_x;
    logic              mul_y;
    logic              coord_x;
    logic              coord_y;
    logic              rd_center;
    logic              paint;
    logic              st_we;
    logic [STAT_W-1:0] st_val;
    logic              out_load;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic             is_clear;
    logic             lvl_bad;
    logic             outside;
    logic             center_hit;
    logic [RAD_W-1:0] radius;
  } sts_t;

  // Largest horizontal offset inside the disk of radius rad on a row d away.
  function automatic logic [RAD_W-1:0] disk_half(input logic [RAD_W-1:0] rad,
                                                 input logic [RAD_W-1:0] d);
    logic [RAD_W-1:0] h;
    int               lim;
    h   = '0;
    lim = int'(rad) * int'(rad) - int'(d) * int'(d);
    for (int i = 0; i < (1 << RAD_W); i++) begin
      if (i * i <= lim) begin
        h = RAD_W'(i);
      end
    end
    return h;
  endfunction

endpackage

/* rtl/gdnms_in_if.sv */
// Input channel: one feature test or one mask clear per transaction.
`timescale 1ns / 1ps
interface gdnms_in_if;
  import gdnms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [ID_W-1:0]         feature_id;
  logic signed [LOC_W-1:0] loc_x;
  logic signed [LOC_W-1:0] loc_y;
  logic [LVL_W-1:0]        scale_level;

  modport source (output valid, kind, feature_id, loc_x, loc_y, scale_level,
                  input ready);
  modport sink (input valid, kind, feature_id, loc_x, loc_y, scale_level,
                output ready);
endinterface

/* rtl/gdnms_out_if.sv */
// Result channel: feature index and decision per transaction.
`timescale 1ns / 1ps
interface gdnms_out_if;
  import gdnms_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   feature_id_res;
  logic [STAT_W-1:0] status;

  modport source (output valid, feature_id_res, status, input ready);
  modport sink (input valid, feature_id_res, status, output ready);
endinterface

/* rtl/gdnms_cfg_if.sv */
// Configuration write channel: register index and data per transaction.
`timescale 1ns / 1ps
interface gdnms_cfg_if;
  import gdnms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/gdnms_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module gdnms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* rtl/gdnms_ctrl.sv */
// Sequencer: steps one transaction through bin mapping, center test and disk paint.
`timescale 1ns / 1ps
module gdnms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gdnms_pkg::cmd_t   cmd,
  input  gdnms_pkg::sts_t   sts
);
  import gdnms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_MY    = 3'd2;
  localparam logic [2:0] S_CY    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_PAINT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.cnt       = cnt_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        priority if (sts.is_clear) begin
          cmd.clear  = 1'b1;
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_CLEARED;
          state_nxt  = S_DONE;
        end else if (sts.lvl_bad) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else begin
          cmd.mul_x = 1'b1;
          state_nxt = S_MY;
        end
      end
      S_MY: begin
        cmd.coord_x = 1'b1;
        cmd.mul_y   = 1'b1;
        state_nxt   = S_CY;
      end
      S_CY: begin
        cmd.coord_y = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        if (sts.outside) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_OUTSIDE;
          state_nxt  = S_DONE;
        end else begin
          // A count equal to the radius addresses the center row.
          cmd.rd_center = 1'b1;
          cmd.cnt       = {1'b0, sts.radius};
          state_nxt     = S_TEST;
        end
      end
      S_TEST: begin
        cmd.st_we = 1'b1;
        if (sts.center_hit) begin
          cmd.st_val = ST_SUPPRESS;
          state_nxt  = S_DONE;
        end else begin
          cmd.st_val = ST_ACCEPT;
          cnt_nxt    = '0;
          state_nxt  = S_PAINT;
        end
      end
      S_PAINT: begin
        // Each step reads one disk row and writes back the row read before it.
        cmd.paint = 1'b1;
        if (cnt_r == {sts.radius, 1'b1}) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

/* rtl/gdnms_dp.sv */
// Datapath: configuration registers, bin mapping, mask memory and result register.
`timescale 1ns / 1ps
module gdnms_dp #(
  parameter int GRID_W          = 64,
  parameter int GRID_H          = 64,
  parameter int SCALES          = 4,
  parameter int MAX_DISK_RADIUS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gdnms_pkg::cmd_t                     cmd,
  output gdnms_pkg::sts_t                     sts,
  input  logic                                in_kind,
  input  logic [gdnms_pkg::ID_W-1:0]          in_feature_id,
  input  logic signed [gdnms_pkg::LOC_W-1:0]  in_loc_x,
  input  logic signed [gdnms_pkg::LOC_W-1:0]  in_loc_y,
  input  logic [gdnms_pkg::LVL_W-1:0]         in_scale_level,
  input  logic                                cfg_we,
  input  logic [gdnms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdnms_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [gdnms_pkg::ID_W-1:0]          res_id,
  output logic [gdnms_pkg::STAT_W-1:0]        res_status
);
  import gdnms_pkg::*;

  localparam int XW    = $clog2(GRID_W);
  localparam int YW    = $clog2(GRID_H);
  localparam int DEPTH = SCALES * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = XW + 2;

  // Configuration registers.
  logic [INV_W-1:0]        inv_r;
  logic signed [OFF_W-1:0] offx_r;
  logic signed [OFF_W-1:0] offy_r;
  logic [RAD_W-1:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= INV_W'(65536);
      offx_r <= OFF_W'(128);
      offy_r <= OFF_W'(128);
      rad_r  <= RAD_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_RADIUS:  inv_r  <= cfg_data[INV_W-1:0];
        REG_OFFSET_X:    offx_r <= cfg_data[OFF_W-1:0];
        REG_OFFSET_Y:    offy_r <= cfg_data[OFF_W-1:0];
        REG_DISK_RADIUS: rad_r  <= cfg_data[RAD_W-1:0];
      endcase
    end
  end

  logic [RAD_W-1:0] r;
  assign r = (int'(rad_r) > MAX_DISK_RADIUS) ? RAD_W'(MAX_DISK_RADIUS) : rad_r;

  // Captured transaction.
  logic                    kind_r;
  logic [ID_W-1:0]         id_r;
  logic signed [LOC_W-1:0] locx_r;
  logic signed [LOC_W-1:0] locy_r;
  logic [LVL_W-1:0]        lvl_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      id_r   <= in_feature_id;
      locx_r <= in_loc_x;
      locy_r <= in_loc_y;
      lvl_r  <= in_scale_level;
    end
  end

  // Shared multiplier, x then y.
  logic signed [LOC_W-1:0]  mul_loc;
  logic signed [PROD_W-1:0] prod_full;
  logic signed [PROD_W-1:0] prod_r;

  assign mul_loc   = cmd.mul_y ? locy_r : locx_r;
  assign prod_full = mul_loc * $signed({1'b0, inv_r});

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= prod_full;
    end
  end

  // Q.20 sum, truncation toward zero, floor shift by level, then padding.
  logic signed [OFF_W-1:0] off_sel;
  logic signed [RAW_W-1:0] raw;
  logic signed [BIN_W-1:0] bin_q;
  logic signed [BIN_W-1:0] bin_t;
  logic signed [BIN_W-1:0] bin_s;
  logic                    rnd;
  logic signed [CW-1:0]    coord;
  logic signed [CW-1:0]    px_r;
  logic signed [CW-1:0]    py_r;

  assign off_sel = cmd.coord_y ? offy_r : offx_r;
  assign raw     = $signed({prod_r[PROD_W-1], prod_r})
                 + $signed({{(RAW_W - OFF_W - 12){off_sel[OFF_W-1]}}, off_sel, 12'b0});
  assign bin_q   = raw[RAW_W-1:FRAC_W];
  assign rnd     = raw[RAW_W-1] && (raw[FRAC_W-1:0] != '0);
  assign bin_t   = bin_q + $signed({{(BIN_W-1){1'b0}}, rnd});
  assign bin_s   = bin_t >>> lvl_r;
  assign coord   = $signed({bin_s[BIN_W-1], bin_s}) + $signed({{(CW-RAD_W){1'b0}}, r});

  always_ff @(posedge clk) begin
    if (cmd.coord_x) begin
      px_r <= coord;
    end
    if (cmd.coord_y) begin
      py_r <= coord;
    end
  end

  // Row addressing for the center test and the disk rows.
  logic signed [CW-1:0] ys;
  logic                 row_ok;
  logic [AW-1:0]        base;
  logic [AW-1:0]        rd_addr;
  logic [CNT_W-1:0]     dabs;
  logic [RAD_W-1:0]     h;

  assign ys      = py_r + $signed({{(CW-CNT_W){1'b0}}, cmd.cnt})
                 - $signed({{(CW-RAD_W){1'b0}}, r});
  assign row_ok  = !ys[CW-1] && (ys < $signed(CW'(GRID_H)));
  assign base    = AW'(int'(lvl_r) * GRID_H);
  assign rd_addr = base + AW'(ys[YW-1:0]);
  assign dabs    = (cmd.cnt >= CNT_W'(r)) ? (cmd.cnt - CNT_W'(r)) : (CNT_W'(r) - cmd.cnt);
  assign h       = disk_half(r, dabs[RAD_W-1:0]);

  // Rows never written since the last clear read as empty.
  logic [DEPTH-1:0] row_valid_r;
  logic             rvalid_r;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    prev_addr_r;
  logic             prev_ok_r;
  logic [RAD_W-1:0] prev_h_r;
  logic [GRID_W-1:0] rd_data;
  logic [GRID_W-1:0] eff_row;
  logic [GRID_W-1:0] disk_mask;
  logic [GRID_W-1:0] wr_data;
  logic signed [LW-1:0] px_ext;
  logic signed [LW-1:0] lo;
  logic signed [LW-1:0] hi;

  assign rd_en = cmd.rd_center || cmd.paint;
  assign wr_en = cmd.paint && (cmd.cnt != '0) && prev_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (cmd.clear) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[prev_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rvalid_r <= row_valid_r[rd_addr];
    end
    if (cmd.paint) begin
      prev_addr_r <= rd_addr;
      prev_ok_r   <= row_ok;
      prev_h_r    <= h;
    end
  end

  gdnms_ram #(
    .WIDTH (GRID_W),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (prev_addr_r),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign eff_row = rvalid_r ? rd_data : '0;
  assign px_ext  = $signed({2'b00, px_r[XW-1:0]});
  assign lo      = px_ext - $signed({{(LW-RAD_W){1'b0}}, prev_h_r});
  assign hi      = px_ext + $signed({{(LW-RAD_W){1'b0}}, prev_h_r});

  always_comb begin
    for (int x = 0; x < GRID_W; x++) begin
      disk_mask[x] = ($signed(LW'(x)) >= lo) && ($signed(LW'(x)) <= hi);
    end
  end

  assign wr_data = eff_row | disk_mask;

  // Decision and result registers.
  logic [STAT_W-1:0] st_r;
  logic [ID_W-1:0]   res_id_r;
  logic [STAT_W-1:0] res_status_r;

  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      st_r <= cmd.st_val;
    end
    if (cmd.out_load) begin
      res_id_r     <= id_r;
      res_status_r <= st_r;
    end
  end

  assign res_id     = res_id_r;
  assign res_status = res_status_r;

  assign sts.is_clear   = kind_r;
  assign sts.lvl_bad    = int'(lvl_r) >= SCALES;
  assign sts.outside    = px_r[CW-1] || (px_r >= $signed(CW'(GRID_W)))
                       || py_r[CW-1] || (py_r >= $signed(CW'(GRID_H)));
  assign sts.center_hit = eff_row[px_r[XW-1:0]];
  assign sts.radius     = r;
endmodule

/* rtl/grid_disk_nonmax_suppressor_unit.sv */
// Top level of the grid disk non-maximum suppressor.
// A transaction is loaded, decoded, binned in x and then y, checked against the grid
// and tested at its center; an accepted feature then paints the 2r+1 rows of its disk
// (r is the saturated disk radius). A mask clear or a level out of range skips to the result.
// A new transaction is taken only after the last result is loaded, so throughput is set by the
// row-at-a-time read-modify-write of the mask RAM; a finished result may wait at the output.
// Reset (synchronous, rst_n low) empties all masks at once and loads register defaults.
`timescale 1ns / 1ps
module grid_disk_nonmax_suppressor_unit #(
  parameter int GRID_W          = 64,
  parameter int GRID_H          = 64,
  parameter int SCALES          = 4,
  parameter int MAX_DISK_RADIUS = 8
) (
  input logic         clk,
  input logic         rst_n,
  gdnms_in_if.sink    in_ch,
  gdnms_out_if.source out_ch,
  gdnms_cfg_if.sink   cfg_ch
);
  import gdnms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  gdnms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gdnms_dp #(
    .GRID_W          (GRID_W),
    .GRID_H          (GRID_H),
    .SCALES          (SCALES),
    .MAX_DISK_RADIUS (MAX_DISK_RADIUS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_feature_id  (in_ch.feature_id),
    .in_loc_x       (in_ch.loc_x),
    .in_loc_y       (in_ch.loc_y),
    .in_scale_level (in_ch.scale_level),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .res_id         (out_ch.feature_id_res),
    .res_status     (out_ch.status)
  );
endmodule

/* rtl/gdnms_checker.sv */
// Port-level checker for the suppressor and its bind to the top level.
`timescale 1ns / 1ps
module gdnms_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gdnms_pkg::ID_W-1:0]     out_id,
  input logic [gdnms_pkg::STAT_W-1:0]   out_status
);
  import gdnms_pkg::*;

  // Transactions accepted but not yet delivered.
  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_status))
    else $error("stalled result changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted transaction");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n) pend_r != 2'd3)
    else $error("more than one transaction in flight besides a waiting result");
endmodule

bind grid_disk_nonmax_suppressor_unit gdnms_checker u_gdnms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_id     (out_ch.feature_id_res),
  .out_status (out_ch.status)
);

/* tb/tb_grid_disk_nonmax_suppressor_unit.sv */
// Self-checking testbench for the grid disk non-maximum suppressor top level.
`timescale 1ns / 1ps
module tb_grid_disk_nonmax_suppressor_unit;
  import gdnms_pkg::*;

  localparam int GRID_W          = 64;
  localparam int GRID_H          = 64;
  localparam int SCALES          = 4;
  localparam int MAX_DISK_RADIUS = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_PRINTED     = 100;

  localparam logic KIND_TEST  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [LOC_W-1:0] x;
    logic [LOC_W-1:0] y;
    logic [LVL_W-1:0] lvl;
  } feature_req_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [STAT_W-1:0] status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  gdnms_in_if  in_ch();
  gdnms_out_if out_ch();
  gdnms_cfg_if cfg_ch();

  grid_disk_nonmax_suppressor_unit #(
    .GRID_W         (GRID_W),
    .GRID_H         (GRID_H),
    .SCALES         (SCALES),
    .MAX_DISK_RADIUS(MAX_DISK_RADIUS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Occupancy masks and register copies of the suppressor as the checker sees them.
  logic [GRID_W-1:0] cover_map [SCALES*GRID_H];
  logic [INV_W-1:0]  cur_inv;
  logic [OFF_W-1:0]  cur_off_x;
  logic [OFF_W-1:0]  cur_off_y;
  logic [RAD_W-1:0]  cur_radius;

  feature_req_t pending [$];
  verdict_t     verdicts_due [$];
  feature_req_t next_req;

  logic in_fire, out_fire, cfg_fire;
  int   in_gap, out_stall;
  bit   in_calm, out_calm;
  int   quiet_cycles;
  int   mismatches;
  int   n_accept, n_suppress, n_outside, n_clear, n_settings;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  // Appends one transaction to the tail of the driver's queue.
  task automatic enqueue_req(input feature_req_t rq);
    pending.insert(pending.size(), rq);
  endtask

  // Padded bin on one axis: truncate the Q.20 sum toward zero, floor-shift by level.
  function automatic longint padded_bin(input logic [LOC_W-1:0] loc,
                                        input logic [OFF_W-1:0] off,
                                        input int lvl, input int rad);
    longint raw, bin;
    raw = longint'(signed'(loc)) * longint'(cur_inv) + longint'(signed'(off)) * 4096;
    bin = (raw >= 0) ? (raw >>> 20) : -((-raw) >>> 20);
    return (bin >>> lvl) + rad;
  endfunction

  task automatic decide_feature(input feature_req_t rq, output logic [STAT_W-1:0] st);
    longint px, py;
    int     rad, cx, cy, base;
    if (rq.kind == KIND_CLEAR) begin
      foreach (cover_map[k]) cover_map[k] = '0;
      st = ST_CLEARED;
    end else begin
      rad = (cur_radius > MAX_DISK_RADIUS) ? MAX_DISK_RADIUS : int'(cur_radius);
      px  = padded_bin(rq.x, cur_off_x, int'(rq.lvl), rad);
      py  = padded_bin(rq.y, cur_off_y, int'(rq.lvl), rad);
      if (px < 0 || px >= GRID_W || py < 0 || py >= GRID_H) begin
        st = ST_OUTSIDE;
      end else begin
        cx   = int'(px);
        cy   = int'(py);
        base = int'(rq.lvl) * GRID_H;
        if (cover_map[base + cy][cx]) begin
          st = ST_SUPPRESS;
        end else begin
          // Bins of the disk that fall off the grid edge are simply dropped.
          for (int dj = -rad; dj <= rad; dj++) begin
            for (int di = -rad; di <= rad; di++) begin
              if (di * di + dj * dj <= rad * rad && cx + di >= 0 && cx + di < GRID_W &&
                  cy + dj >= 0 && cy + dj < GRID_H) begin
                cover_map[base + cy + dj][cx + di] = 1'b1;
              end
            end
          end
          st = ST_ACCEPT;
        end
      end
    end
  endtask

  function automatic feature_req_t feature(input logic kind, input int id, input int x,
                                           input int y, input int lvl);
    feature_req_t rq;
    rq.kind = kind;
    rq.id   = ID_W'(id);
    rq.x    = LOC_W'(x);
    rq.y    = LOC_W'(y);
    rq.lvl  = LVL_W'(lvl);
    return rq;
  endfunction

  // Picks a location whose padded bin lands in or just around the grid at this level.
  function automatic logic [LOC_W-1:0] aim_loc(input logic [OFF_W-1:0] off, input int lvl,
                                               input int span);
    longint bin, num, loc;
    int     rs;
    if (cur_inv == '0) begin
      return LOC_W'($urandom);
    end
    rs  = (cur_radius > MAX_DISK_RADIUS) ? MAX_DISK_RADIUS : int'(cur_radius);
    bin = (longint'($urandom_range(0, span + 3)) - 2 - rs) * (longint'(1) << lvl) +
          longint'($urandom_range(0, (1 << lvl) - 1));
    num = bin * 1048576 + longint'($urandom_range(0, 1048575)) -
          longint'(signed'(off)) * 4096;
    loc = num / longint'(cur_inv);
    if (loc > 262143) loc = 262143;
    if (loc < -262144) loc = -262144;
    return LOC_W'(loc);
  endfunction

  function automatic feature_req_t random_request();
    feature_req_t rq;
    int           pick;
    rq.kind = KIND_TEST;
    rq.id   = ID_W'($urandom);
    rq.lvl  = LVL_W'($urandom);
    rq.x    = LOC_W'($urandom);
    rq.y    = LOC_W'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 3) begin
      rq.kind = KIND_CLEAR;
    end else if (pick >= 12) begin
      rq.x = aim_loc(cur_off_x, int'(rq.lvl), GRID_W);
      rq.y = aim_loc(cur_off_y, int'(rq.lvl), GRID_H);
    end
    return rq;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  // Returns once every queued transaction is accepted and every result has come back.
  task automatic wait_drained();
    bit drained;
    drained = 1'b0;
    while (!drained) begin
      @(posedge clk);
      if (pending.size() == 0 && !in_ch.valid) begin
        @(negedge clk);
        drained = (verdicts_due.size() == 0);
      end
    end
  endtask

  task automatic run_phase(input logic [INV_W-1:0] inv, input logic [OFF_W-1:0] ox,
                           input logic [OFF_W-1:0] oy, input logic [RAD_W-1:0] rad,
                           input int n);
    wait_drained();
    write_reg(REG_INV_RADIUS, CFG_DATA_W'(inv));
    write_reg(REG_OFFSET_X, CFG_DATA_W'(ox));
    write_reg(REG_OFFSET_Y, CFG_DATA_W'(oy));
    write_reg(REG_DISK_RADIUS, CFG_DATA_W'(rad));
    n_settings++;
    @(posedge clk);
    repeat (n) enqueue_req(random_request());
  endtask

  // Input driver: presents queued transactions with a random gap after each one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_ch.valid) begin
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 13);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        next_req = pending.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= next_req.kind;
        in_ch.feature_id  <= next_req.id;
        in_ch.loc_x       <= next_req.x;
        in_ch.loc_y       <= next_req.y;
        in_ch.scale_level <= next_req.lvl;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: a random stall after each accepted result.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 13);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every input transaction and checks every result transaction.
  always @(posedge clk) begin
    verdict_t          due;
    feature_req_t      rq;
    logic [STAT_W-1:0] st;
    in_fire  <= rst_n && in_ch.valid && in_ch.ready;
    out_fire <= rst_n && out_ch.valid && out_ch.ready;
    cfg_fire <= rst_n && cfg_ch.valid && cfg_ch.ready;
    if (!rst_n) begin
      foreach (cover_map[k]) cover_map[k] = '0;
      cur_inv      = INV_W'(65536);
      cur_off_x    = OFF_W'(128);
      cur_off_y    = OFF_W'(128);
      cur_radius   = RAD_W'(1);
      quiet_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result id %h status %0d",
                                    out_ch.feature_id_res, out_ch.status));
        end else begin
          due = verdicts_due.pop_front();
          if (out_ch.feature_id_res !== due.id) begin
            report_mismatch($sformatf("feature_id_res %h, predicted %h",
                                      out_ch.feature_id_res, due.id));
          end
          if (out_ch.status !== due.status) begin
            report_mismatch($sformatf("status %0d for id %h, predicted %0d",
                                      out_ch.status, due.id, due.status));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        rq.kind = in_ch.kind;
        rq.id   = in_ch.feature_id;
        rq.x    = in_ch.loc_x;
        rq.y    = in_ch.loc_y;
        rq.lvl  = in_ch.scale_level;
        decide_feature(rq, st);
        due.id     = rq.id;
        due.status = st;
        verdicts_due.insert(verdicts_due.size(), due);
        case (st)
          ST_ACCEPT:   n_accept++;
          ST_SUPPRESS: n_suppress++;
          ST_OUTSIDE:  n_outside++;
          default:     n_clear++;
        endcase
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_INV_RADIUS:  cur_inv    = cfg_ch.data[INV_W-1:0];
          REG_OFFSET_X:    cur_off_x  = cfg_ch.data[OFF_W-1:0];
          REG_OFFSET_Y:    cur_off_y  = cfg_ch.data[OFF_W-1:0];
          REG_DISK_RADIUS: cur_radius = cfg_ch.data[RAD_W-1:0];
          default: ;
        endcase
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, verdicts_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_TEST;
    in_ch.feature_id  = '0;
    in_ch.loc_x       = '0;
    in_ch.loc_y       = '0;
    in_ch.scale_level = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_INV_RADIUS;
    cfg_ch.data       = '0;
    in_gap = 0;
    out_stall = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    mismatches = 0;
    n_accept = 0;
    n_suppress = 0;
    n_outside = 0;
    n_clear = 0;
    n_settings = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one bin per 16 pixels, half a bin of rounding, disk radius one.
    enqueue_req(feature(KIND_TEST, 16'h0000, 0, 0, 0));
    enqueue_req(feature(KIND_TEST, 16'hFFFF, 0, 0, 0));
    enqueue_req(feature(KIND_TEST, 16'h0002, 16, 0, 0));
    enqueue_req(feature(KIND_TEST, 16'h0003, 32, 0, 0));
    // Small negative locations truncate toward zero before the floor shift.
    enqueue_req(feature(KIND_TEST, 16'h0004, -32, -32, 0));
    enqueue_req(feature(KIND_TEST, 16'h0005, -48, 0, 0));
    // Far corner: part of the disk falls off the grid.
    enqueue_req(feature(KIND_TEST, 16'h0006, 992, 992, 0));
    enqueue_req(feature(KIND_TEST, 16'h0007, 1008, 0, 0));
    enqueue_req(feature(KIND_TEST, 16'h0008, 262143, 0, 0));
    enqueue_req(feature(KIND_TEST, 16'h0009, -262144, -262144, 0));
    enqueue_req(feature(KIND_TEST, 16'h000A, 0, 262143, 2));
    enqueue_req(feature(KIND_TEST, 16'h000B, 0, 0, 1));
    enqueue_req(feature(KIND_TEST, 16'h000C, 0, 0, 2));
    enqueue_req(feature(KIND_TEST, 16'h000D, 0, 0, 3));
    enqueue_req(feature(KIND_TEST, 16'h000E, -32, -32, 3));
    enqueue_req(feature(KIND_TEST, 16'h000F, 1600, 1600, 3));
    enqueue_req(feature(KIND_TEST, 16'h0010, 1680, 1600, 3));
    enqueue_req(feature(KIND_CLEAR, 16'h1234, -1, -1, 3));
    enqueue_req(feature(KIND_TEST, 16'h5A5A, 0, 0, 0));
    enqueue_req(feature(KIND_CLEAR, 16'h0000, 0, 0, 0));
    repeat (250) enqueue_req(random_request());

    run_phase(INV_W'(1048575), 24'h800000, 24'h7FFFFF, 4'd0, 250);
    run_phase(INV_W'(0), OFF_W'(1357), OFF_W'(10440), 4'd15, 80);
    run_phase(INV_W'(1), 24'h7FFFFF, 24'h800000, 4'd8, 30);
    run_phase(INV_W'($urandom_range(20000, 200000)),
              OFF_W'(int'($urandom_range(0, 4096)) - 2048),
              OFF_W'(int'($urandom_range(0, 4096)) - 2048),
              RAD_W'($urandom_range(2, 7)), 400);
    run_phase(INV_W'(32768), OFF_W'(0), OFF_W'(0), 4'd8, 250);
    run_phase(INV_W'(65536), OFF_W'(128), OFF_W'(128), 4'd3, 250);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived", verdicts_due.size()));
    end
    $display("Covered %0d accepted, %0d suppressed, %0d off-grid features and %0d clears,",
             n_accept, n_suppress, n_outside, n_clear);
    $display("under %0d register settings; %0d mismatches seen.", n_settings, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gdnms_pkg.sv
rtl/gdnms_in_if.sv
rtl/gdnms_out_if.sv
rtl/gdnms_cfg_if.sv
rtl/gdnms_ram.sv
rtl/gdnms_ctrl.sv
rtl/gdnms_dp.sv
rtl/grid_disk_nonmax_suppressor_unit.sv
rtl/gdnms_checker.sv
tb/tb_grid_disk_nonmax_suppressor_unit.sv
